### sv/fkarm_pkg.sv
//------------------------------------------------------------------------------
// fkarm_pkg
// Shared types, constants and CORDIC angle table for the arm kinematics core.
//------------------------------------------------------------------------------
package fkarm_pkg;

    localparam int TRIG_BITS = 16;
    localparam int ANG_W     = 16;
    localparam int LEN_W     = 16;
    localparam int POS_W     = 19;
    localparam int Z_W       = 34;
    localparam int T_W       = TRIG_BITS + 3;
    localparam int POS_LIMIT = 196605;

    localparam logic [63:0] CORDIC_GAIN_Q32 = 64'd2608131496;
    localparam logic [63:0] GAIN_SUM =
        CORDIC_GAIN_Q32 + (64'd1 << (31 - TRIG_BITS));
    localparam logic [63:0] GAIN_SHR = GAIN_SUM >> (32 - TRIG_BITS);
    localparam logic signed [T_W-1:0] X_INIT = T_W'(GAIN_SHR);

    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_BASE  = 2'd0;
    localparam t_cfg_idx CFG_UPPER = 2'd1;
    localparam t_cfg_idx CFG_FORE  = 2'd2;

    typedef struct packed {
        logic signed [T_W-1:0] sin_v;
        logic signed [T_W-1:0] cos_v;
    } t_trig;

    function automatic logic [31:0] atan_turn(input int i);
        logic [31:0] r;
        case (i)
            0: r = 32'h20000000;  1: r = 32'h12E4051E;
            2: r = 32'h09FB385B;  3: r = 32'h051111D4;
            4: r = 32'h028B0D43;  5: r = 32'h0145D7E1;
            6: r = 32'h00A2F61E;  7: r = 32'h00517C55;
            8: r = 32'h0028BE53;  9: r = 32'h00145F2F;
            10: r = 32'h000A2F98; 11: r = 32'h000517CC;
            12: r = 32'h00028BE6; 13: r = 32'h000145F3;
            14: r = 32'h0000A2FA; 15: r = 32'h0000517D;
            16: r = 32'h000028BE; 17: r = 32'h0000145F;
            18: r = 32'h00000A30; 19: r = 32'h00000518;
            20: r = 32'h0000028C; 21: r = 32'h00000146;
            22: r = 32'h000000A3; 23: r = 32'h00000051;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

endpackage

### sv/fkarm_cordic.sv
//------------------------------------------------------------------------------
// fkarm_cordic
// Unrolled rotation-mode CORDIC, one register stage per iteration.
//------------------------------------------------------------------------------
module fkarm_cordic (
    input  logic                      i_clk,
    input  logic [fkarm_pkg::ANG_W-1:0] i_angle,
    output fkarm_pkg::t_trig          o_trig
);
    import fkarm_pkg::*;

    logic signed [T_W-1:0] r_x [0:TRIG_BITS];
    logic signed [T_W-1:0] r_y [0:TRIG_BITS];
    logic signed [Z_W-1:0] r_z [0:TRIG_BITS];
    logic                  r_f [0:TRIG_BITS];

    logic signed [Z_W-1:0] n_z0;
    logic                  n_f0;
    logic signed [Z_W-1:0] w_z;

    always_comb begin
        w_z  = Z_W'(signed'({i_angle, 16'h0000}));
        n_z0 = w_z;
        n_f0 = 1'b0;
        if (w_z > (Z_W'(1) <<< 30)) begin
            n_z0 = w_z - (Z_W'(1) <<< 31);
            n_f0 = 1'b1;
        end else if (w_z < -(Z_W'(1) <<< 30)) begin
            n_z0 = w_z + (Z_W'(1) <<< 31);
            n_f0 = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x[0] <= X_INIT;
        r_y[0] <= '0;
        r_z[0] <= n_z0;
        r_f[0] <= n_f0;
    end

    for (genvar g = 0; g < TRIG_BITS; g++) begin : g_step
        localparam logic signed [Z_W-1:0] STEP = Z_W'(atan_turn(g));
        always_ff @(posedge i_clk) begin
            r_f[g+1] <= r_f[g];
            if (!r_z[g][Z_W-1]) begin
                r_x[g+1] <= r_x[g] - (r_y[g] >>> g);
                r_y[g+1] <= r_y[g] + (r_x[g] >>> g);
                r_z[g+1] <= r_z[g] - STEP;
            end else begin
                r_x[g+1] <= r_x[g] + (r_y[g] >>> g);
                r_y[g+1] <= r_y[g] - (r_x[g] >>> g);
                r_z[g+1] <= r_z[g] + STEP;
            end
        end
    end

    assign o_trig.cos_v = r_f[TRIG_BITS] ? -r_x[TRIG_BITS] : r_x[TRIG_BITS];
    assign o_trig.sin_v = r_f[TRIG_BITS] ? -r_y[TRIG_BITS] : r_y[TRIG_BITS];

endmodule

### sv/fkarm_combine.sv
//------------------------------------------------------------------------------
// fkarm_combine
// Link products, rounding, base rotation and saturation over four stages.
//------------------------------------------------------------------------------
module fkarm_combine (
    input  logic                        i_clk,
    input  fkarm_pkg::t_trig            i_t1,
    input  fkarm_pkg::t_trig            i_t2,
    input  fkarm_pkg::t_trig            i_t23,
    input  logic [fkarm_pkg::LEN_W-1:0] i_l1,
    input  logic [fkarm_pkg::LEN_W-1:0] i_l2,
    input  logic [fkarm_pkg::LEN_W-1:0] i_l3,
    output logic signed [fkarm_pkg::POS_W-1:0] o_x,
    output logic signed [fkarm_pkg::POS_W-1:0] o_y,
    output logic signed [fkarm_pkg::POS_W-1:0] o_z
);
    import fkarm_pkg::*;

    localparam int P_W = T_W + LEN_W + 1;
    localparam int S_W = P_W + 1;
    localparam int R_W = S_W - TRIG_BITS;
    localparam int M_W = T_W + R_W;
    localparam int H_W = R_W + 1;

    logic signed [P_W-1:0] r_ps2, r_ps3, r_pc2, r_pc3;
    t_trig                 r_t1a, r_t1b;
    logic [LEN_W-1:0]      r_l1a, r_l1b;
    logic signed [R_W-1:0] r_r, r_h;
    logic signed [M_W-1:0] r_mx, r_my;
    logic signed [H_W-1:0] r_hz;
    logic signed [S_W-1:0] n_rs, n_hs;
    logic signed [M_W-1:0] n_xs, n_ys;

    function automatic logic signed [POS_W-1:0] sat(input logic signed [M_W-1:0] v);
        if (v > M_W'(POS_LIMIT)) return POS_W'(POS_LIMIT);
        if (v < -M_W'(POS_LIMIT)) return -POS_W'(POS_LIMIT);
        return v[POS_W-1:0];
    endfunction

    always_comb begin
        n_rs = S_W'(r_ps2) + S_W'(r_ps3) + (S_W'(1) <<< (TRIG_BITS - 1));
        n_hs = S_W'(r_pc2) + S_W'(r_pc3) + (S_W'(1) <<< (TRIG_BITS - 1));
        n_xs = r_mx + (M_W'(1) <<< (TRIG_BITS - 1));
        n_ys = r_my + (M_W'(1) <<< (TRIG_BITS - 1));
    end

    always_ff @(posedge i_clk) begin
        r_ps2 <= P_W'(i_t2.sin_v  * signed'({1'b0, i_l2}));
        r_ps3 <= P_W'(i_t23.sin_v * signed'({1'b0, i_l3}));
        r_pc2 <= P_W'(i_t2.cos_v  * signed'({1'b0, i_l2}));
        r_pc3 <= P_W'(i_t23.cos_v * signed'({1'b0, i_l3}));
        r_t1a <= i_t1;
        r_l1a <= i_l1;

        r_r   <= R_W'(n_rs >>> TRIG_BITS);
        r_h   <= R_W'(n_hs >>> TRIG_BITS);
        r_t1b <= r_t1a;
        r_l1b <= r_l1a;

        r_mx  <= M_W'(r_t1b.sin_v * r_r);
        r_my  <= M_W'(r_t1b.cos_v * r_r);
        r_hz  <= H_W'(r_h) + H_W'({1'b0, r_l1b});

        o_x   <= sat(n_xs >>> TRIG_BITS);
        o_y   <= sat(n_ys >>> TRIG_BITS);
        o_z   <= sat(M_W'(r_hz));
    end

endmodule

### sv/forward_kinematics_three_joint_arm_core.sv
//------------------------------------------------------------------------------
// forward_kinematics_three_joint_arm_core
// End point of a base-yaw, two-pitch arm from three joint angles.
//------------------------------------------------------------------------------
// One joint-angle set is taken every cycle; busy is never raised. A result
// passes through 17 unrolled CORDIC stages (TRIG_BITS iterations plus range
// folding) and four arithmetic stages, then strobes out on o_valid. The receiver
// cannot stall: capture each result in the cycle o_valid is high. Link lengths
// are sampled when the set enters the arithmetic stages; write them while
// no item is in flight.
module forward_kinematics_three_joint_arm_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [fkarm_pkg::ANG_W-1:0]          i_base_angle,
    input  logic [fkarm_pkg::ANG_W-1:0]          i_shoulder_angle,
    input  logic [fkarm_pkg::ANG_W-1:0]          i_elbow_angle,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [1:0]                          i_cfg_index,
    input  logic [fkarm_pkg::LEN_W-1:0]          i_cfg_data,
    output logic                                o_valid,
    output logic signed [fkarm_pkg::POS_W-1:0]  o_pos_x,
    output logic signed [fkarm_pkg::POS_W-1:0]  o_pos_y,
    output logic signed [fkarm_pkg::POS_W-1:0]  o_pos_z
);
    import fkarm_pkg::*;

    localparam int LAT = TRIG_BITS + 5;

    logic [LEN_W-1:0] r_l1, r_l2, r_l3;
    logic [LAT-1:0]   r_vld;
    logic [ANG_W-1:0] w_a23;
    t_trig            w_t1, w_t2, w_t23;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_a23       = i_shoulder_angle + i_elbow_angle;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_l1  <= 16'd2048;
            r_l2  <= 16'd4096;
            r_l3  <= 16'd6144;
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[LAT-2:0], start};
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_BASE:  r_l1 <= i_cfg_data;
                    CFG_UPPER: r_l2 <= i_cfg_data;
                    CFG_FORE:  r_l3 <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    fkarm_cordic u_c1  (.i_clk(i_clk), .i_angle(i_base_angle),     .o_trig(w_t1));
    fkarm_cordic u_c2  (.i_clk(i_clk), .i_angle(i_shoulder_angle), .o_trig(w_t2));
    fkarm_cordic u_c23 (.i_clk(i_clk), .i_angle(w_a23),            .o_trig(w_t23));

    fkarm_combine u_comb (
        .i_clk (i_clk),
        .i_t1  (w_t1),
        .i_t2  (w_t2),
        .i_t23 (w_t23),
        .i_l1  (r_l1),
        .i_l2  (r_l2),
        .i_l3  (r_l3),
        .o_x   (o_pos_x),
        .o_y   (o_pos_y),
        .o_z   (o_pos_z)
    );

    assign o_valid = r_vld[LAT-1];

endmodule

### sv/fkarm_checker.sv
//------------------------------------------------------------------------------
// fkarm_checker
// Port-level checks of the arm kinematics core.
//------------------------------------------------------------------------------
module fkarm_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               o_valid,
    input logic signed [fkarm_pkg::POS_W-1:0] o_pos_x,
    input logic signed [fkarm_pkg::POS_W-1:0] o_pos_y,
    input logic signed [fkarm_pkg::POS_W-1:0] o_pos_z
);
    import fkarm_pkg::*;

    localparam int LAT = TRIG_BITS + 5;

    a_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_valid) else $error("beat lost");
    a_no_busy: assert property (@(posedge i_clk) !busy) else $error("busy raised");
    a_sat_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pos_x <= POS_W'(POS_LIMIT) && o_pos_x >= -POS_W'(POS_LIMIT)))
        else $error("x out of range");
    a_sat_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pos_z <= POS_W'(POS_LIMIT) && o_pos_z >= -POS_W'(POS_LIMIT)))
        else $error("z out of range");
    a_sat_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pos_y <= POS_W'(POS_LIMIT) && o_pos_y >= -POS_W'(POS_LIMIT)))
        else $error("y out of range");

endmodule

bind forward_kinematics_three_joint_arm_core fkarm_checker u_chk (.*);

### bench/testbench.sv
//------------------------------------------------------------------------------
// testbench
// Drives joint-angle sets into the arm kinematics core and checks each end
// point against a bit-exact CORDIC prediction, over several link settings.
//------------------------------------------------------------------------------
module testbench;
    import fkarm_pkg::*;

    localparam int LATENCY     = 21;
    localparam int CYCLE_LIMIT = 400000;
    localparam t_cfg_idx CFG_NONE = 2'd3;

    typedef struct {
        logic signed [POS_W-1:0] px;
        logic signed [POS_W-1:0] py;
        logic signed [POS_W-1:0] pz;
    } t_point;

    typedef struct {
        logic [15:0] a1;
        logic [15:0] a2;
        logic [15:0] a3;
        bit          typed;
        int          ex;
        int          ey;
        int          ez;
    } t_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic [ANG_W-1:0]           i_base_angle;
    logic [ANG_W-1:0]           i_shoulder_angle;
    logic [ANG_W-1:0]           i_elbow_angle;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [1:0]                 i_cfg_index;
    logic [LEN_W-1:0]           i_cfg_data;
    logic                       o_valid;
    logic signed [POS_W-1:0]    o_pos_x;
    logic signed [POS_W-1:0]    o_pos_y;
    logic signed [POS_W-1:0]    o_pos_z;

    logic [15:0] len_base, len_upper, len_fore;
    t_point      pending_points[$];
    int          mismatches;
    int          cycles;
    t_row        rows[$];

    forward_kinematics_three_joint_arm_core DUT (.*);

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic longint floor_shr(longint v, int n);
        return v >>> n;
    endfunction

    function automatic longint round_shr(longint v, int n);
        return floor_shr(v + (longint'(1) << (n - 1)), n);
    endfunction

    function automatic longint clamp_pos(longint v);
        if (v > POS_LIMIT) return POS_LIMIT;
        if (v < -POS_LIMIT) return -POS_LIMIT;
        return v;
    endfunction

    function automatic void sincos(input logic [15:0] ang, output longint s,
                                   output longint c);
        longint z, x, y, xn, stp;
        bit     flip;
        z = longint'({ang, 16'h0});
        flip = 0;
        if (z >= (longint'(1) << 31)) z -= (longint'(1) << 32);
        if (z > (longint'(1) << 30)) begin
            z -= (longint'(1) << 31);
            flip = 1;
        end else if (z < -(longint'(1) << 30)) begin
            z += (longint'(1) << 31);
            flip = 1;
        end
        x = longint'((64'd2608131496 + (64'd1 << (31 - TRIG_BITS))) >> (32 - TRIG_BITS));
        y = 0;
        for (int i = 0; i < TRIG_BITS; i++) begin
            stp = longint'(atan_turn(i));
            if (z >= 0) begin
                xn = x - floor_shr(y, i);
                y = y + floor_shr(x, i);
                z -= stp;
            end else begin
                xn = x + floor_shr(y, i);
                y = y - floor_shr(x, i);
                z += stp;
            end
            x = xn;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic t_point end_point(logic [15:0] a1, logic [15:0] a2, logic [15:0] a3);
        longint s1, c1, s2, c2, s23, c23, r, h;
        logic [15:0] a23;
        t_point p;
        a23 = a2 + a3;
        sincos(a1, s1, c1);
        sincos(a2, s2, c2);
        sincos(a23, s23, c23);
        r = round_shr(longint'(len_upper) * s2 + longint'(len_fore) * s23, TRIG_BITS);
        h = round_shr(longint'(len_upper) * c2 + longint'(len_fore) * c23, TRIG_BITS);
        p.px = POS_W'(clamp_pos(round_shr(s1 * r, TRIG_BITS)));
        p.py = POS_W'(clamp_pos(round_shr(c1 * r, TRIG_BITS)));
        p.pz = POS_W'(clamp_pos(longint'(len_base) + h));
        return p;
    endfunction

    always @(posedge i_clk) begin
        t_point want;
        if (i_rst_n && o_valid) begin
            if (pending_points.size() == 0) begin
                $error("unexpected beat x=%0d y=%0d z=%0d", o_pos_x, o_pos_y, o_pos_z);
                mismatches++;
            end else begin
                want = pending_points.pop_front();
                if (o_pos_x !== want.px) begin
                    $error("pos_x expected %0d actual %0d", want.px, o_pos_x);
                    mismatches++;
                end
                if (o_pos_y !== want.py) begin
                    $error("pos_y expected %0d actual %0d", want.py, o_pos_y);
                    mismatches++;
                end
                if (o_pos_z !== want.pz) begin
                    $error("pos_z expected %0d actual %0d", want.pz, o_pos_z);
                    mismatches++;
                end
            end
        end
    end

    task automatic write_len(input t_cfg_idx idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_BASE:  len_base  = val;
            CFG_UPPER: len_upper = val;
            CFG_FORE:  len_fore  = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic drain();
        while (pending_points.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 4) @(negedge i_clk);
    endtask

    task automatic send_set(input logic [15:0] a1, input logic [15:0] a2,
                            input logic [15:0] a3, input bit last_in_burst);
        start            <= 1'b1;
        i_base_angle     <= a1;
        i_shoulder_angle <= a2;
        i_elbow_angle    <= a3;
        do @(posedge i_clk); while (busy);
        pending_points = {pending_points, end_point(a1, a2, a3)};
        @(negedge i_clk);
        if (last_in_burst) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
    endtask

    task automatic random_sets(input int count);
        int left, burst;
        logic [15:0] a1, a2, a3;
        left = count;
        while (left > 0) begin
            burst = int'($urandom_range(1, 40));
            if (burst > left) burst = left;
            for (int k = 0; k < burst; k++) begin
                a1 = 16'($urandom);
                a2 = 16'($urandom);
                a3 = 16'($urandom);
                if ($urandom_range(0, 7) == 0) a1 = 16'(16'h4000 * $urandom_range(0, 3));
                if ($urandom_range(0, 7) == 0) a2 = 16'(16'h4000 * $urandom_range(0, 3));
                send_set(a1, a2, a3, k == burst - 1);
            end
            left -= burst;
            if ($urandom_range(0, 3) != 0) repeat ($urandom_range(0, 6)) @(negedge i_clk);
        end
    endtask

    function automatic t_row mk(logic [15:0] a1, logic [15:0] a2, logic [15:0] a3,
                                bit typed = 0, int ex = 0, int ey = 0, int ez = 0);
        t_row r;
        r.a1 = a1; r.a2 = a2; r.a3 = a3;
        r.typed = typed; r.ex = ex; r.ey = ey; r.ez = ez;
        return r;
    endfunction

    initial begin
        t_point p;
        mismatches = 0;
        cycles = 0;
        i_rst_n = 1'b0;
        start = 1'b0;
        i_base_angle = '0;
        i_shoulder_angle = '0;
        i_elbow_angle = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_BASE;
        i_cfg_data = '0;
        len_base = 16'd2048;
        len_upper = 16'd4096;
        len_fore = 16'd6144;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // arm straight up at reset lengths: z = 0.5 + 1.0 + 1.5
        rows = {rows, mk(16'h0000, 16'h0000, 16'h0000, 1, 0, 0, 12288)};
        rows = {rows, mk(16'hFFFF, 16'hFFFF, 16'hFFFF)};
        rows = {rows, mk(16'h4000, 16'h4000, 16'h0000)};
        rows = {rows, mk(16'h8000, 16'h8000, 16'h8000)};
        rows = {rows, mk(16'hC000, 16'hC000, 16'h4000)};
        rows = {rows, mk(16'h4001, 16'h3FFF, 16'hBFFF)};
        rows = {rows, mk(16'hC001, 16'hBFFF, 16'h8001)};
        rows = {rows, mk(16'h2000, 16'hF000, 16'h2000)};
        rows = {rows, mk(16'h5555, 16'hAAAA, 16'h5555)};
        rows = {rows, mk(16'h0001, 16'h8001, 16'h7FFF)};
        foreach (rows[i]) begin
            send_set(rows[i].a1, rows[i].a2, rows[i].a3, 1);
            if (rows[i].typed) begin
                p = pending_points[$];
                if (p.px != rows[i].ex || p.py != rows[i].ey || p.pz != rows[i].ez) begin
                    $error("prediction disagrees with table row %0d", i);
                    mismatches++;
                end
            end
        end
        drain();

        // longest links: z can reach the saturation limit
        write_len(CFG_BASE, 16'hFFFF);
        write_len(CFG_UPPER, 16'hFFFF);
        write_len(CFG_FORE, 16'hFFFF);
        foreach (rows[i]) send_set(rows[i].a1, rows[i].a2, rows[i].a3, 1);
        random_sets(150);
        drain();

        write_len(CFG_BASE, 16'h0000);
        write_len(CFG_UPPER, 16'h0000);
        write_len(CFG_FORE, 16'h0000);
        random_sets(100);
        drain();

        for (int phase = 0; phase < 5; phase++) begin
            write_len(CFG_BASE, 16'($urandom));
            write_len(CFG_UPPER, 16'($urandom));
            write_len(CFG_FORE, 16'($urandom));
            write_len(CFG_NONE, 16'($urandom));
            random_sets(200);
            drain();
        end

        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
